/* design/aes_pkg.sv */
`default_nettype none

package aes_pkg;

    localparam int BLOCK_W  = 128;
    localparam int HALF_W   = 64;
    localparam int CFG_IDX_W = 8;
    localparam int ROUND_W  = 4;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd1;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    localparam logic [7:0] GF_POLY  = 8'h1b;
    localparam logic [7:0] GF_MSB   = 8'h80;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // byte 0 sits in the top bits of the 128-bit block
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        logic [7:0] s;
        s = {a[6:0], 1'b0};
        if ((a & GF_MSB) != 8'h00)
            s = s ^ GF_POLY;
        return s;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                t[BLOCK_W-1-8*(4*col+row) -: 8] =
                    SBOX[get_byte(s, 4*((col+row) % 4) + row)];
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int col = 0; col < 4; col++) begin
            a0  = get_byte(s, 4*col);
            a1  = get_byte(s, 4*col+1);
            a2  = get_byte(s, 4*col+2);
            a3  = get_byte(s, 4*col+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*col)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLOCK_W-1-8*(4*col+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLOCK_W-1-8*(4*col+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLOCK_W-1-8*(4*col+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // one step of the key schedule: rotword, subword, rcon, xor chain
    function automatic logic [BLOCK_W-1:0] next_key(input logic [BLOCK_W-1:0] rk,
                                                    input logic [7:0] rc);
        logic [31:0] w, w0, w1, w2, w3;
        w  = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
              SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
        w0 = rk[127:96] ^ w;
        w1 = rk[95:64]  ^ w0;
        w2 = rk[63:32]  ^ w1;
        w3 = rk[31:0]   ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

/* design/aes128_block_encrypt_top.sv */
`default_nettype none

// AES-128 encryption of one 128-bit block per input word, ECB style. The
// initial key addition is done as the block is taken in. A single shared round
// unit follows: sixteen s-boxes, mix columns (skipped in the last round) and
// key addition, one round per cycle but for the stall below. The result word
// is registered at the end of the last round, after which the next block can
// be accepted. Round keys are derived on the fly from the two key registers by
// a key schedule step with four s-boxes that runs alongside the round unit, so
// a key write takes effect with the next block and needs no expansion pass.
// s_tready is high only while no block is in flight. A finished result waits
// in the output register, and the next block may be accepted meanwhile. If
// that result is still waiting when the last round of the next block is
// reached, the block holds there until the output word is taken. The
// configuration port is always ready; indexes other than 0 and 1 are ignored.
module aes128_block_encrypt_top
    import aes_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [BLOCK_W-1:0]   s_tdata,    // block_high, block_low

    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [BLOCK_W-1:0]   m_tdata,    // cipher_high, cipher_low

    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HALF_W-1:0]    cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } fsm_t;

    fsm_t                 fsm_reg;
    logic [ROUND_W-1:0]   round_reg;
    logic [BLOCK_W-1:0]   state_reg;
    logic [BLOCK_W-1:0]   rkey_reg;
    logic [HALF_W-1:0]    key_high_reg;
    logic [HALF_W-1:0]    key_low_reg;
    logic                 out_valid_reg;
    logic [BLOCK_W-1:0]   out_data_reg;

    logic [BLOCK_W-1:0]   key_full;
    logic [BLOCK_W-1:0]   block_in;
    logic [BLOCK_W-1:0]   rkey_next;
    logic [BLOCK_W-1:0]   subbed;
    logic [BLOCK_W-1:0]   state_next;
    logic                 last_round;
    logic                 out_free;
    logic                 round_done;

    assign key_full   = {key_high_reg, key_low_reg};
    assign block_in   = {s_tdata[HALF_W-1:0], s_tdata[BLOCK_W-1:HALF_W]};
    assign last_round = (round_reg == LAST_ROUND);
    assign out_free   = !out_valid_reg || m_tready;
    assign round_done = (fsm_reg == ST_ROUND) && last_round && out_free;

    always_comb begin
        rkey_next  = next_key(rkey_reg, rcon(round_reg));
        subbed     = sub_shift(state_reg);
        state_next = (last_round ? subbed : mix_columns(subbed)) ^ rkey_next;
    end

    assign s_tready  = (fsm_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= ST_IDLE;
            round_reg     <= FIRST_ROUND;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_KEY_HIGH)
                    key_high_reg <= cfg_data;
                else if (cfg_index == REG_KEY_LOW)
                    key_low_reg <= cfg_data;
            end

            if (round_done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (fsm_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= block_in ^ key_full;
                        rkey_reg  <= key_full;
                        round_reg <= FIRST_ROUND;
                        fsm_reg   <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    if (!last_round) begin
                        state_reg <= state_next;
                        rkey_reg  <= rkey_next;
                        round_reg <= round_reg + 1'b1;
                    end else if (out_free) begin
                        // last round stalls here until the output word is free
                        out_data_reg  <= {state_next[HALF_W-1:0],
                                          state_next[BLOCK_W-1:HALF_W]};
                        fsm_reg       <= ST_IDLE;
                    end
                end
                default: fsm_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
